// File: src/ili_pkg.sv
// Shared constants, codes and types for the indexed list core.
`timescale 1ns / 1ps

package ili_pkg;

    // Default list depth and fixed field widths
    localparam int ILI_DEPTH = 64;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 6;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_DELETE = 3'd3,
        OP_INSERT = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Result fields with fixed widths, handed from sequencer to output stage
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        t_status                  status;
    } t_result;

endpackage

// File: src/indexed_list_insert_delete_core.sv
// Top level of the indexed list core: sequencer, entry store and output register.
`timescale 1ns / 1ps

// One request at a time. Append, write, unknown codes, delete of the last
// entry, insert at the end and any request that fails its checks go from
// idle straight to the finish state. A read first waits for the store's
// registered read data. Delete at p below count-1 moves count-p-1 entries;
// insert at p below count moves count-p entries and then writes the new
// value. Entries move one per cycle through the store's read and write
// ports. The next request is taken the cycle after the result is loaded
// into the output register, which holds it until the consumer takes it.
// While that register is still full, a finished request waits and no new
// request is taken. Reset empties the list at once; there is no clearing
// pass.
module indexed_list_insert_delete_core import ili_pkg::*; #(
    parameter int DEPTH = ILI_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic        [OP_W-1:0]         i_operation,
    input  logic        [POS_W-1:0]        i_position,
    input  logic signed [DATA_W-1:0]       i_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [DATA_W-1:0]       o_read_data,
    output logic        [$clog2(DEPTH+1)-1:0] o_length,
    output logic        [ST_W-1:0]         o_status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);

    logic              we, re, done, out_free;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;
    t_result           seq_res;
    logic [LEN_W-1:0]  seq_len;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_read_data;
    logic [LEN_W-1:0]         r_length;
    t_status                  r_status;

    ili_seq #(.DEPTH(DEPTH), .AW(AW), .LEN_W(LEN_W)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_operation(i_operation),
        .i_position (i_position),
        .i_value    (i_value),
        .i_out_free (out_free),
        .o_done     (done),
        .o_result   (seq_res),
        .o_length   (seq_len),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    ili_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_read_data <= seq_res.data;
            r_length    <= seq_len;
            r_status    <= seq_res.status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_length    = r_length;
    assign o_status    = r_status;

endmodule

// File: src/ili_ram.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ili_ram import ili_pkg::*; #(
    parameter int DEPTH = ILI_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ili_seq.sv
// Request sequencer: range checks, entry moves and count update.
`timescale 1ns / 1ps

module ili_seq import ili_pkg::*; #(
    parameter int DEPTH = ILI_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int LEN_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    // result side
    input  logic              i_out_free,
    output logic              o_done,
    output t_result           o_result,
    output logic [LEN_W-1:0]  o_length,
    // memory side
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [DATA_W-1:0] o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  logic [DATA_W-1:0] i_rdata
);

    // compare width able to hold both a position and the full count
    localparam int CW = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDWAIT = 5'b00010,
        S_MOVE   = 5'b00100,
        S_INSPUT = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_count, n_count;
    logic [AW-1:0]     r_wptr, n_wptr;
    logic [AW-1:0]     r_rptr, n_rptr;
    logic [AW-1:0]     r_stop, n_stop;
    logic [AW-1:0]     r_pos, n_pos;
    logic [DATA_W-1:0] r_val, n_val;
    logic              r_up, n_up;
    t_result           r_res, n_res;

    logic [CW-1:0] pos_ext, cnt_ext, cnt_m1, cnt_m2;
    logic [AW-1:0] pos_a;
    logic          pos_lt, is_full;

    // Operand views of position and count
    assign pos_ext = CW'(i_position);
    assign cnt_ext = CW'(r_count);
    assign cnt_m1  = cnt_ext - CW'(1);
    assign cnt_m2  = cnt_ext - CW'(2);
    assign pos_a   = pos_ext[AW-1:0];
    assign pos_lt  = pos_ext < cnt_ext;
    assign is_full = r_count == LEN_W'(DEPTH);

    // Next state and memory access
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_stop  = r_stop;
        n_pos   = r_pos;
        n_val   = r_val;
        n_up    = r_up;
        n_res   = r_res;
        o_we    = 1'b0;
        o_waddr = r_wptr;
        o_wdata = i_rdata;
        o_re    = 1'b0;
        o_raddr = r_rptr;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res   = '{data: '0, status: ST_OK};
                    n_state = S_FINISH;
                    case (t_op'(i_operation))
                        OP_APPEND: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = cnt_ext[AW-1:0];
                                o_wdata = i_value;
                                n_count = r_count + LEN_W'(1);
                            end
                        end
                        OP_READ: begin
                            if (!pos_lt) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = pos_a;
                                n_state = S_RDWAIT;
                            end
                        end
                        OP_WRITE: begin
                            if (!pos_lt) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                o_we    = 1'b1;
                                o_waddr = pos_a;
                                o_wdata = i_value;
                            end
                        end
                        OP_DELETE: begin
                            if (!pos_lt) begin
                                n_res.status = ST_RANGE;
                            end else if (pos_ext == cnt_m1) begin
                                // last entry: nothing to close up
                                n_count = r_count - LEN_W'(1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = pos_a + AW'(1);
                                n_wptr  = pos_a;
                                n_rptr  = pos_a + AW'(2);
                                n_stop  = cnt_m2[AW-1:0];
                                n_up    = 1'b0;
                                n_state = S_MOVE;
                            end
                        end
                        OP_INSERT: begin
                            if (is_full) begin
                                n_res.status = ST_FULL;
                            end else if (pos_ext > cnt_ext) begin
                                n_res.status = ST_RANGE;
                            end else if (pos_ext == cnt_ext) begin
                                // insert at the end acts as an append
                                o_we    = 1'b1;
                                o_waddr = pos_a;
                                o_wdata = i_value;
                                n_count = r_count + LEN_W'(1);
                            end else begin
                                o_re    = 1'b1;
                                o_raddr = cnt_m1[AW-1:0];
                                n_wptr  = cnt_ext[AW-1:0];
                                n_rptr  = cnt_m2[AW-1:0];
                                n_stop  = pos_a + AW'(1);
                                n_pos   = pos_a;
                                n_val   = i_value;
                                n_up    = 1'b1;
                                n_state = S_MOVE;
                            end
                        end
                        default: begin
                            // unknown code: no change, ok status
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_res.data = i_rdata;
                n_state    = S_FINISH;
            end
            S_MOVE: begin
                // write back the entry fetched last cycle, fetch the next unless at the stop
                o_we    = 1'b1;
                o_waddr = r_wptr;
                o_wdata = i_rdata;
                if (r_wptr == r_stop) begin
                    if (r_up) begin
                        n_state = S_INSPUT;
                    end else begin
                        n_count = r_count - LEN_W'(1);
                        n_state = S_FINISH;
                    end
                end else begin
                    o_re    = 1'b1;
                    o_raddr = r_rptr;
                    n_rptr  = r_up ? (r_rptr - AW'(1)) : (r_rptr + AW'(1));
                    n_wptr  = r_up ? (r_wptr - AW'(1)) : (r_wptr + AW'(1));
                end
            end
            S_INSPUT: begin
                o_we    = 1'b1;
                o_waddr = r_pos;
                o_wdata = r_val;
                n_count = r_count + LEN_W'(1);
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_wptr <= n_wptr;
        r_rptr <= n_rptr;
        r_stop <= n_stop;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_up   <= n_up;
        r_res  <= n_res;
    end

    assign o_ready  = r_state == S_IDLE;
    assign o_result = r_res;
    assign o_length = r_count;

    // The two ports never touch the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_we && o_re) |-> (o_waddr != o_raddr))
        else $error("read and write at the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(DEPTH))
        else $error("entry count beyond depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while one is in progress");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (o_ready && !o_done))
        else $error("sequencer did not return to idle after a result");

endmodule
